[rtl/core/aclp_pkg.sv]
// Package for the ASCII command line parser: byte classes, token and
// field-phase types, character codes and reset values. No dependencies.
`timescale 1ns / 1ps

package aclp_pkg;

	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_R     = 8'h52;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_VT    = 8'h0B;
	localparam logic [7:0] CHAR_FF    = 8'h0C;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [15:0] DEFAULT_DELAY_RST = 16'd800;

	typedef enum logic [3:0] {
		CLS_NEWLINE,
		CLS_CR,
		CLS_NUL,
		CLS_BLANK,
		CLS_PLUS,
		CLS_MINUS,
		CLS_DIGIT,
		CLS_COMMA,
		CLS_R,
		CLS_OTHER
	} tok_cls_t;

	typedef struct packed {
		tok_cls_t   cls;
		logic [3:0] dval;
	} token_t;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_DIGITS,
		PH_DONE
	} phase_t;

endpackage

[rtl/core/aclp_if.sv]
// Channel interfaces of the command line parser: received bytes in,
// parsed results out. Uses no package.
`timescale 1ns / 1ps

interface aclp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface aclp_res_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [15:0] x_error;
	logic signed [15:0] y_error;
	logic signed [31:0] rect_width;
	logic signed [31:0] rect_height;
	logic        [15:0] rect_delay;

	modport source (output valid, output kind, output x_error, output y_error,
		output rect_width, output rect_height, output rect_delay, input ready);
	modport sink (input valid, input kind, input x_error, input y_error,
		input rect_width, input rect_height, input rect_delay, output ready);
endinterface

[rtl/core/ascii_command_line_parser.sv]
// Top level of the ASCII command line parser: config register, classifier,
// token queue and line parser. Depends on aclp_pkg, aclp_if and submodules.
//
//  channel | dir | payload                                          | handshake
//  rx      | in  | rx_byte[7:0]                                     | valid/ready
//  res     | out | kind, x_error, y_error, rect_width/height, delay | valid/ready
//  cfg     | in  | cfg_wdata[15:0] (default_delay)                  | cfg_we
//
// One byte per cycle sustained while results are taken; the line parser does one multiply-by-ten
// accumulate per byte, which sets that figure.
// A newline's result is valid after the classifier token register, a queue entry and the result register.
// arst_n clears all line state and sets default_delay to 800.
// A stalled result holds back only newlines; other bytes keep flowing through the
// two-entry queue until a newline reaches its head.
`timescale 1ns / 1ps

module ascii_command_line_parser #(
	parameter int LINE_CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	aclp_rx_if.sink     rx,
	aclp_res_if.source  res
);

	logic [15:0]      default_delay_q;
	logic             cls_valid;
	logic             cls_ready;
	aclp_pkg::token_t cls_tok;
	logic             q_valid;
	logic             q_ready;
	aclp_pkg::token_t q_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_delay_q <= aclp_pkg::DEFAULT_DELAY_RST;
		end else if (cfg_we) begin
			default_delay_q <= cfg_wdata;
		end
	end

	aclp_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.tok_valid (cls_valid),
		.tok_ready (cls_ready),
		.tok       (cls_tok)
	);

	aclp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cls_valid),
		.in_ready  (cls_ready),
		.in_tok    (cls_tok),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_tok   (q_tok)
	);

	aclp_exec #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_exec (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_valid     (q_valid),
		.tok_ready     (q_ready),
		.tok           (q_tok),
		.default_delay (default_delay_q),
		.res           (res)
	);

endmodule

[rtl/core/aclp_classify.sv]
// Front end: takes received bytes, classifies them and registers a token.
// Carriage returns are taken and dropped here. Depends on aclp_pkg.
`timescale 1ns / 1ps

module aclp_classify (
	input  logic            clk,
	input  logic            arst_n,
	aclp_rx_if.sink         rx,
	output logic            tok_valid,
	input  logic            tok_ready,
	output aclp_pkg::token_t tok
);

	aclp_pkg::tok_cls_t cls;
	logic               tok_valid_s1;
	aclp_pkg::token_t   tok_s1;
	logic               rx_fire;
	logic               move;

	always_comb begin
		unique case (rx.rx_byte) inside
			aclp_pkg::CHAR_LF: cls = aclp_pkg::CLS_NEWLINE;
			aclp_pkg::CHAR_CR: cls = aclp_pkg::CLS_CR;
			aclp_pkg::CHAR_NUL: cls = aclp_pkg::CLS_NUL;
			aclp_pkg::CHAR_SPACE, aclp_pkg::CHAR_TAB, aclp_pkg::CHAR_VT,
			aclp_pkg::CHAR_FF: cls = aclp_pkg::CLS_BLANK;
			aclp_pkg::CHAR_PLUS: cls = aclp_pkg::CLS_PLUS;
			aclp_pkg::CHAR_MINUS: cls = aclp_pkg::CLS_MINUS;
			[aclp_pkg::CHAR_ZERO:aclp_pkg::CHAR_NINE]: cls = aclp_pkg::CLS_DIGIT;
			aclp_pkg::CHAR_COMMA: cls = aclp_pkg::CLS_COMMA;
			aclp_pkg::CHAR_R: cls = aclp_pkg::CLS_R;
			default: cls = aclp_pkg::CLS_OTHER;
		endcase
	end

	assign move     = tok_valid_s1 && tok_ready;
	assign rx.ready = !tok_valid_s1 || tok_ready;
	assign rx_fire  = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
		end else if (rx_fire) begin
			tok_valid_s1 <= (cls != aclp_pkg::CLS_CR);
		end else if (move) begin
			tok_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire) begin
			tok_s1.cls  <= cls;
			tok_s1.dval <= rx.rx_byte[3:0];
		end
	end

	assign tok_valid = tok_valid_s1;
	assign tok       = tok_s1;

endmodule

[rtl/core/aclp_queue.sv]
// Two-entry token queue between classifier and line parser, so either
// side may stall alone. Depends on aclp_pkg.
`timescale 1ns / 1ps

module aclp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  aclp_pkg::token_t in_tok,
	output logic             out_valid,
	input  logic             out_ready,
	output aclp_pkg::token_t out_tok
);

	aclp_pkg::token_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_tok   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_tok;
		end
	end

endmodule

[rtl/core/aclp_exec.sv]
// Back end: line state, on-the-fly field accumulation and the result
// register. Depends on aclp_pkg and aclp_if.
`timescale 1ns / 1ps

module aclp_exec #(
	parameter int LINE_CAPACITY = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_valid,
	output logic             tok_ready,
	input  aclp_pkg::token_t tok,
	input  logic [15:0]      default_delay,
	aclp_res_if.source       res
);

	localparam int CNT_W = $clog2(LINE_CAPACITY);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_CAPACITY - 1);

	logic [CNT_W-1:0] char_count_q, char_count_d;
	logic             first_is_r_q, first_is_r_d;
	logic [1:0]       comma_count_q, comma_count_d;
	logic             text_ended_q, text_ended_d;
	aclp_pkg::phase_t phase_q, phase_d;
	logic             negative_q, negative_d;
	logic [31:0]      field_q [4];
	logic [31:0]      field_wdata;
	logic [1:0]       field_widx;
	logic             field_we;
	logic             clear_all;

	logic [31:0]      cur_field;
	logic [31:0]      times_ten;
	logic [31:0]      digit_ext;
	logic             tok_fire;
	logic             is_nl;
	logic             emit;

	logic               res_valid_q;
	logic               kind_q;
	logic signed [15:0] x_error_q;
	logic signed [15:0] y_error_q;
	logic signed [31:0] rect_width_q;
	logic signed [31:0] rect_height_q;
	logic        [15:0] rect_delay_q;

	assign is_nl     = (tok.cls == aclp_pkg::CLS_NEWLINE);
	assign tok_ready = !res_valid_q || res.ready || !is_nl;
	assign tok_fire  = tok_valid && tok_ready;

	assign cur_field = field_q[comma_count_q];
	assign times_ten = {cur_field[28:0], 3'b000} + {cur_field[30:0], 1'b0};
	assign digit_ext = {28'd0, tok.dval};

	// a newline gives a result for an R line with at least two commas, or any other
	// line with at least one comma
	assign emit = tok_fire && is_nl &&
		(first_is_r_q ? (comma_count_q >= 2'd2) : (comma_count_q != 2'd0));

	always_comb begin
		char_count_d  = char_count_q;
		first_is_r_d  = first_is_r_q;
		comma_count_d = comma_count_q;
		text_ended_d  = text_ended_q;
		phase_d       = phase_q;
		negative_d    = negative_q;
		field_we      = 1'b0;
		field_widx    = comma_count_q;
		field_wdata   = negative_q ? (times_ten - digit_ext) : (times_ten + digit_ext);
		clear_all     = 1'b0;
		if (tok_fire) begin
			if (is_nl || char_count_q == CNT_FULL) begin
				// end of line, or overflow: drop the byte and start afresh
				clear_all = 1'b1;
			end else begin
				char_count_d = char_count_q + CNT_W'(1);
				if (!text_ended_q) begin
					if (tok.cls == aclp_pkg::CLS_NUL) begin
						text_ended_d = 1'b1;
					end else begin
						if (char_count_q == '0) begin
							first_is_r_d = (tok.cls == aclp_pkg::CLS_R);
						end
						if (tok.cls == aclp_pkg::CLS_COMMA) begin
							if (comma_count_q != 2'd3) begin
								comma_count_d = comma_count_q + 2'd1;
								phase_d       = aclp_pkg::PH_SKIP;
								negative_d    = 1'b0;
								field_we      = 1'b1;
								field_widx    = comma_count_q + 2'd1;
								field_wdata   = '0;
							end else begin
								phase_d = aclp_pkg::PH_DONE;
							end
						end else begin
							unique case (phase_q)
								aclp_pkg::PH_SKIP: begin
									case (tok.cls) inside
										aclp_pkg::CLS_BLANK: phase_d = aclp_pkg::PH_SKIP;
										aclp_pkg::CLS_PLUS, aclp_pkg::CLS_MINUS: begin
											negative_d = (tok.cls == aclp_pkg::CLS_MINUS);
											phase_d    = aclp_pkg::PH_DIGITS;
										end
										aclp_pkg::CLS_DIGIT: begin
											field_we = 1'b1;
											phase_d  = aclp_pkg::PH_DIGITS;
										end
										default: phase_d = aclp_pkg::PH_DONE;
									endcase
								end
								aclp_pkg::PH_DIGITS: begin
									if (tok.cls == aclp_pkg::CLS_DIGIT) begin
										field_we = 1'b1;
									end else begin
										phase_d = aclp_pkg::PH_DONE;
									end
								end
								default: phase_d = phase_q;
							endcase
						end
					end
				end
			end
			if (clear_all) begin
				char_count_d  = '0;
				first_is_r_d  = 1'b0;
				comma_count_d = 2'd0;
				text_ended_d  = 1'b0;
				phase_d       = aclp_pkg::PH_SKIP;
				negative_d    = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q  <= '0;
			first_is_r_q  <= 1'b0;
			comma_count_q <= 2'd0;
			text_ended_q  <= 1'b0;
			phase_q       <= aclp_pkg::PH_SKIP;
			negative_q    <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				field_q[i] <= '0;
			end
		end else begin
			char_count_q  <= char_count_d;
			first_is_r_q  <= first_is_r_d;
			comma_count_q <= comma_count_d;
			text_ended_q  <= text_ended_d;
			phase_q       <= phase_d;
			negative_q    <= negative_d;
			if (clear_all) begin
				for (int i = 0; i < 4; i++) begin
					field_q[i] <= '0;
				end
			end else if (field_we) begin
				field_q[field_widx] <= field_wdata;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= first_is_r_q;
			if (first_is_r_q) begin
				x_error_q     <= '0;
				y_error_q     <= '0;
				rect_width_q  <= field_q[1];
				rect_height_q <= field_q[2];
				rect_delay_q  <= (comma_count_q == 2'd3) ? field_q[3][15:0] : default_delay;
			end else begin
				x_error_q     <= field_q[0][15:0];
				y_error_q     <= field_q[1][15:0];
				rect_width_q  <= '0;
				rect_height_q <= '0;
				rect_delay_q  <= '0;
			end
		end
	end

	assign res.valid       = res_valid_q;
	assign res.kind        = kind_q;
	assign res.x_error     = x_error_q;
	assign res.y_error     = y_error_q;
	assign res.rect_width  = rect_width_q;
	assign res.rect_height = rect_height_q;
	assign res.rect_delay  = rect_delay_q;

	a_line_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		tok_fire && is_nl |=> char_count_q == '0 && comma_count_q == 2'd0 && !first_is_r_q)
		else $error("line state not cleared after newline");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		char_count_q <= CNT_FULL)
		else $error("line length beyond capacity");

	a_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		text_ended_q || first_is_r_q || comma_count_q != 2'd0 |-> char_count_q != '0)
		else $error("line state set with no byte held");

	a_kind_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (kind_q ? (x_error_q == '0 && y_error_q == '0)
			: (rect_width_q == '0 && rect_height_q == '0 && rect_delay_q == '0)))
		else $error("result fields of the other kind not zero");

endmodule
